>>> design/integer_to_radix_digits_core_assert.svh
// Assertion macros used by the datapath.
`ifndef INTEGER_TO_RADIX_DIGITS_CORE_ASSERT_SVH
`define INTEGER_TO_RADIX_DIGITS_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define ITRD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property that must hold in the cycle after a trigger condition.
`define ITRD_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) else $error(msg);

`endif

>>> design/itrd_pkg.sv
package itrd_pkg;

    // Field widths and defaults
    localparam int VALUE_BITS_DEF = 31;
    localparam int RADIX_W        = 6;
    localparam int CHAR_W         = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    // ASCII mapping constants
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'd65;
    localparam logic [CHAR_W-1:0] DEC_DIGITS = 7'd10;

    // Controller to datapath commands
    typedef struct packed {
        logic start;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic bit_last;
        logic quot_zero;
        logic ptr_zero;
        logic out_free;
    } dp_status_t;

    // Clamp the programmed radix into the supported range
    function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end else begin
            res = r;
        end
        return res;
    endfunction

    // Digit value to '0'-'9' / 'A'-'Z'
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        logic [CHAR_W-1:0] res;
        ext = {1'b0, d};
        if (ext < DEC_DIGITS) begin
            res = CHAR_ZERO + ext;
        end else begin
            res = CHAR_A - DEC_DIGITS + ext;
        end
        return res;
    endfunction

endpackage

>>> design/itrd_ctrl.sv
module itrd_ctrl import itrd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_LOAD  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd.start    = 1'b0;
        cmd.div_step = 1'b0;
        cmd.out_load = 1'b0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.bit_last && status.quot_zero) begin
                    state_next = ST_FETCH;
                end
            end
            // wait state for the registered digit buffer read
            ST_FETCH: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = status.ptr_zero ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/itrd_datapath.sv
`include "integer_to_radix_digits_core_assert.svh"

module itrd_datapath import itrd_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [RADIX_W-1:0]    cfg_wr_data,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CHAR_W-1:0]     m_digit_char,
    output logic                  m_last,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status
);

    localparam int IDX_W  = $clog2(VALUE_BITS);
    localparam int BCNT_W = $clog2(VALUE_BITS);
    localparam logic [BCNT_W-1:0] BIT_LAST_IDX = BCNT_W'(VALUE_BITS - 1);

    logic [RADIX_W-1:0]    radix_reg, radix_next;
    logic [RADIX_W-1:0]    base_reg, base_next;
    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [RADIX_W-1:0]    r_reg, r_next;
    logic [BCNT_W-1:0]     bcnt_reg, bcnt_next;
    logic [IDX_W-1:0]      ptr_reg, ptr_next;
    logic [RADIX_W-1:0]    rd_data_reg;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic                  last_reg, last_next;
    logic                  valid_reg, valid_next;

    // digit buffer, least significant digit at index 0
    logic [RADIX_W-1:0]    digit_mem [VALUE_BITS];

    logic [RADIX_W:0]      trial;
    logic [RADIX_W:0]      trial_diff;
    logic                  trial_ge;
    logic [RADIX_W-1:0]    r_step;
    logic [VALUE_BITS-1:0] q_step;
    logic                  digit_wr;

    // One restoring division step: one quotient bit per cycle
    always_comb begin
        trial      = {r_reg, q_reg[VALUE_BITS-1]};
        trial_diff = trial - {1'b0, base_reg};
        trial_ge   = (trial >= {1'b0, base_reg});
        r_step     = trial_ge ? trial_diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
        q_step     = {q_reg[VALUE_BITS-2:0], trial_ge};
    end

    // Status to the controller
    always_comb begin
        status.bit_last  = (bcnt_reg == '0);
        status.quot_zero = (q_step == '0);
        status.ptr_zero  = (ptr_reg == '0);
        status.out_free  = !valid_reg || m_ready;
    end

    assign digit_wr = cmd.div_step && status.bit_last;

    // Division and pointer next state
    always_comb begin
        radix_next = cfg_wr_en ? cfg_wr_data : radix_reg;
        base_next  = base_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        bcnt_next  = bcnt_reg;
        ptr_next   = ptr_reg;
        if (cmd.start) begin
            base_next = effective_radix(radix_reg);
            q_next    = s_value;
            r_next    = '0;
            bcnt_next = BIT_LAST_IDX;
            ptr_next  = '0;
        end else if (cmd.div_step) begin
            q_next = q_step;
            if (status.bit_last) begin
                // digit done: restart remainder for the next digit
                r_next    = '0;
                bcnt_next = BIT_LAST_IDX;
                if (!status.quot_zero) begin
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end else begin
                r_next    = r_step;
                bcnt_next = bcnt_reg - BCNT_W'(1);
            end
        end else if (cmd.out_load && !status.ptr_zero) begin
            ptr_next = ptr_reg - IDX_W'(1);
        end
    end

    // Output register next state
    always_comb begin
        char_next  = char_reg;
        last_next  = last_reg;
        valid_next = valid_reg;
        if (cmd.out_load) begin
            char_next  = digit_to_ascii(rd_data_reg);
            last_next  = status.ptr_zero;
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    // Control and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
            base_reg  <= RADIX_RESET;
            r_reg     <= '0;
            q_reg     <= '0;
            bcnt_reg  <= '0;
            ptr_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            radix_reg <= radix_next;
            base_reg  <= base_next;
            r_reg     <= r_next;
            q_reg     <= q_next;
            bcnt_reg  <= bcnt_next;
            ptr_reg   <= ptr_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    // Digit buffer: one write port, registered read
    always_ff @(posedge aclk) begin
        if (digit_wr) begin
            digit_mem[ptr_reg] <= r_step;
        end
        rd_data_reg <= digit_mem[ptr_reg];
    end

    assign m_valid      = valid_reg;
    assign m_digit_char = char_reg;
    assign m_last       = last_reg;

    `ITRD_ASSERT(a_rem_below_base, aclk, aresetn, r_reg < base_reg, "remainder not below radix")
    `ITRD_ASSERT(a_base_range, aclk, aresetn, (base_reg >= RADIX_MIN) && (base_reg <= RADIX_MAX), "radix out of range")
    `ITRD_ASSERT(a_load_when_free, aclk, aresetn, !cmd.out_load || status.out_free, "output overwritten")
    `ITRD_ASSERT_NEXT(a_ptr_hold_msd, aclk, aresetn, digit_wr && status.quot_zero, $stable(ptr_reg), "pointer moved at end of division")

endmodule

>>> design/integer_to_radix_digits_core.sv
// All D digits (D = digit count) are divided out before m_valid rises.
// Each division step yields one quotient bit; one digit takes VALUE_BITS division steps.
// Per character: buffer read, then output register load once the output is free.
// A new item is accepted once the last character sits in the output register.
// Reset (aresetn low, synchronous) clears control and output valid, sets radix to 10.
module integer_to_radix_digits_core import itrd_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [RADIX_W-1:0]    cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CHAR_W-1:0]     m_digit_char,
    output logic                  m_last
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer
    itrd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Divider, digit buffer and output register
    itrd_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last       (m_last),
        .cmd          (cmd),
        .status       (status)
    );

endmodule
